// File: sv/lpe_pkg.sv
package lpe_pkg;

   // fixed-point format
   localparam int FRAC_BITS = 30;
   localparam int X_W       = 32;
   localparam int ORDER_W   = 6;
   localparam int ORDER_TOP = (1 << ORDER_W) - 1;
   localparam int RES_W     = 48;

   // a polynomial value in [-1,1] needs one bit above the binary point plus sign
   localparam int P_W = 32;
   localparam logic signed [P_W-1:0] ONE_FX = P_W'(1) <<< FRAC_BITS;

   // shared multiplier: magnitudes up to 2^31 by up to 2^30
   localparam int MUL_A_W = 33;
   localparam int MUL_B_W = 32;
   localparam int MUL_P_W = 63;
   localparam int MUL_R_W = 64;

   // recurrence numerator (2i-1)*x*P - (i-1)*P, below 2^38 in magnitude
   localparam int NUM_W  = 39;
   localparam int STEP_W = 38;
   // derivative numerator n*(x*P_n - P_{n-1}), below 2^37 in magnitude
   localparam int D_W = 38;

   // shared divider
   localparam int DVD_W  = 68;
   localparam int DVS_W  = 31;
   localparam int DCNT_W = 7;
   localparam logic [DCNT_W-1:0] STEP_BITS = DCNT_W'(STEP_W);
   localparam logic [DCNT_W-1:0] FULL_BITS = DCNT_W'(DVD_W);

   // function codes
   localparam logic FUNC_POLY  = 1'b0;
   localparam logic FUNC_DERIV = 1'b1;

   typedef struct packed {
      logic                    func;
      logic signed [X_W-1:0]   x_point;
      logic [ORDER_W-1:0]      order;
   } req_type;

   typedef struct packed {
      logic signed [RES_W-1:0] result;
      logic                    domain_error;
   } rsp_type;

   typedef struct packed {
      logic                      start;
      logic                      shift;
      logic signed [MUL_A_W-1:0] a;
      logic signed [MUL_B_W-1:0] b;
   } mul_cmd_type;

   typedef struct packed {
      logic                      done;
      logic signed [MUL_R_W-1:0] result;
   } mul_rsp_type;

   typedef struct packed {
      logic              start;
      logic [DVD_W-1:0]  dividend;
      logic [DVS_W-1:0]  divisor;
      logic [DCNT_W-1:0] bits;
   } div_cmd_type;

   typedef struct packed {
      logic             done;
      logic [DVD_W-1:0] quotient;
   } div_rsp_type;

endpackage

// File: sv/lpe_mul_unit.sv
module lpe_mul_unit (
   input  logic                 clock,
   input  logic                 reset,
   input  lpe_pkg::mul_cmd_type cmd,
   output lpe_pkg::mul_rsp_type rsp
);
   import lpe_pkg::*;

   logic [MUL_A_W-2:0]        a_mag;
   logic [MUL_B_W-2:0]        b_mag;
   logic [MUL_P_W-1:0]        mag_ff, mag_in;
   logic                      neg_ff, neg_in;
   logic                      shift_ff, shift_in;
   logic                      v1_ff, v1_in;
   logic [MUL_P_W-1:0]        scaled;
   logic signed [MUL_R_W-1:0] res_ff, res_in;
   logic                      done_ff, done_in;

   // sign-magnitude operands
   assign a_mag = cmd.a[MUL_A_W-1] ? (MUL_A_W-1)'(-cmd.a) : cmd.a[MUL_A_W-2:0];
   assign b_mag = cmd.b[MUL_B_W-1] ? (MUL_B_W-1)'(-cmd.b) : cmd.b[MUL_B_W-2:0];

   // stage 1: magnitude product
   always_comb begin
      mag_in   = mag_ff;
      neg_in   = neg_ff;
      shift_in = shift_ff;
      v1_in    = cmd.start;
      if (cmd.start) begin
         mag_in   = MUL_P_W'(a_mag) * MUL_P_W'(b_mag);
         neg_in   = cmd.a[MUL_A_W-1] ^ cmd.b[MUL_B_W-1];
         shift_in = cmd.shift;
      end
   end

   // stage 2: when shift is set, drop the fraction bits (truncating the magnitude toward zero), then apply the sign
   assign scaled = shift_ff ? (mag_ff >> FRAC_BITS) : mag_ff;

   always_comb begin
      res_in  = res_ff;
      done_in = v1_ff;
      if (v1_ff) begin
         res_in = neg_ff ? -$signed({1'b0, scaled}) : $signed({1'b0, scaled});
      end
   end

   always_ff @(posedge clock) begin
      mag_ff   <= mag_in;
      neg_ff   <= neg_in;
      shift_ff <= shift_in;
      res_ff   <= res_in;
      if (reset) begin
         v1_ff   <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         v1_ff   <= v1_in;
         done_ff <= done_in;
      end
   end

   assign rsp.done   = done_ff;
   assign rsp.result = res_ff;

endmodule

// File: sv/lpe_div_unit.sv
module lpe_div_unit (
   input  logic                 clock,
   input  logic                 reset,
   input  lpe_pkg::div_cmd_type cmd,
   output lpe_pkg::div_rsp_type rsp
);
   import lpe_pkg::*;

   logic [DVS_W-1:0]  rem_ff, rem_in;
   logic [DVD_W-1:0]  quot_ff, quot_in;
   logic [DVS_W-1:0]  dvs_ff, dvs_in;
   logic [DCNT_W-1:0] cnt_ff, cnt_in;
   logic              run_ff, run_in;
   logic              done_ff, done_in;
   logic [DVS_W:0]    trial;
   logic              fits;

   // one restoring step: bring down the next dividend bit
   assign trial = {rem_ff, quot_ff[DVD_W-1]};
   assign fits  = (trial >= {1'b0, dvs_ff});

   always_comb begin
      rem_in  = rem_ff;
      quot_in = quot_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      run_in  = run_ff;
      done_in = 1'b0;
      if (cmd.start) begin
         rem_in  = '0;
         quot_in = cmd.dividend;
         dvs_in  = cmd.divisor;
         cnt_in  = cmd.bits;
         run_in  = 1'b1;
      end else if (run_ff) begin
         rem_in  = fits ? DVS_W'(trial - {1'b0, dvs_ff}) : DVS_W'(trial);
         quot_in = {quot_ff[DVD_W-2:0], fits};
         cnt_in  = cnt_ff - 1'b1;
         if (cnt_ff == DCNT_W'(1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff  <= rem_in;
      quot_ff <= quot_in;
      dvs_ff  <= dvs_in;
      cnt_ff  <= cnt_in;
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
      end
   end

   assign rsp.done     = done_ff;
   assign rsp.quotient = quot_ff;

endmodule

// File: sv/legendre_polynomial_eval.sv
// channel  | ports                     | direction | handshake
// ---------+---------------------------+-----------+----------------------------------
// request  | start, busy, req_payload  | in        | taken when start && !busy
// response | rsp_strobe, rsp_payload   | out       | valid for one cycle on rsp_strobe
//
// orders 0 and 1 answer in the cycle after the item is taken; the derivative at x = +-1
// answers once x*x is back from the multiplier; P_n needs n-1 recurrence steps, each
// three passes through the shared multiplier and a 38-bit pass through the shared divider;
// the derivative adds x*x up front, two more multiplies and a 68-bit final divide;
// synchronous reset returns the sequencer to idle; no result can be held off
module legendre_polynomial_eval #(
   parameter int MAX_ORDER = 63
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  lpe_pkg::req_type req_payload,
   output logic             rsp_strobe,
   output lpe_pkg::rsp_type rsp_payload
);
   import lpe_pkg::*;

   localparam int N_MAX = (MAX_ORDER < ORDER_TOP) ? MAX_ORDER : ORDER_TOP;
   localparam int N_W   = $clog2(N_MAX + 1);

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DEN,
      ST_XP,
      ST_K1,
      ST_K2,
      ST_DIV,
      ST_D1,
      ST_D2,
      ST_FDIV
   } state_type;

   state_type               state_ff, state_in;
   logic                    func_ff, func_in;
   logic signed [P_W-1:0]   x_ff, x_in;
   logic [N_W-1:0]          n_ff, n_in;
   logic [N_W-1:0]          i_ff, i_in;
   logic signed [P_W-1:0]   pm1_ff, pm1_in;
   logic signed [P_W-1:0]   pm2_ff, pm2_in;
   logic signed [NUM_W-1:0] t1_ff, t1_in;
   logic                    neg_ff, neg_in;
   logic [DVS_W-1:0]        den_ff, den_in;
   mul_cmd_type             mul_cmd_ff, mul_cmd_in;
   div_cmd_type             div_cmd_ff, div_cmd_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   rsp_type                 rsp_ff, rsp_in;

   mul_rsp_type             mul_rsp;
   div_rsp_type             div_rsp;

   logic signed [P_W-1:0]     x_clamp;
   logic [N_W-1:0]            n_req;
   logic signed [P_W-1:0]     prod;
   logic signed [NUM_W-1:0]   term;
   logic signed [NUM_W-1:0]   num;
   logic [STEP_W-1:0]         num_mag;
   logic [STEP_W-1:0]         step_q;
   logic [P_W-1:0]            p_mag;
   logic signed [P_W-1:0]     p_new;
   logic signed [MUL_A_W-1:0] diff;
   logic signed [D_W-1:0]     dnum;
   logic [D_W-2:0]            d_mag;
   logic [DVD_W-1:0]          fq;
   logic                      fq_big;
   logic signed [RES_W-1:0]   fres;
   logic [N_W:0]              k_odd;

   function automatic mul_cmd_type mul_op(input logic shift,
                                          input logic signed [MUL_A_W-1:0] a,
                                          input logic signed [MUL_B_W-1:0] b);
      mul_cmd_type c;
      c.start = 1'b1;
      c.shift = shift;
      c.a     = a;
      c.b     = b;
      return c;
   endfunction

   // request conditioning: clamp x to [-1,1] and the order to its maximum
   assign x_clamp = (req_payload.x_point > ONE_FX)  ? ONE_FX :
                    (req_payload.x_point < -ONE_FX) ? -ONE_FX : req_payload.x_point;
   assign n_req   = (int'(req_payload.order) > N_MAX) ? N_W'(N_MAX)
                                                      : N_W'(req_payload.order);

   // multiplier results at the widths each step needs
   assign prod  = $signed(mul_rsp.result[P_W-1:0]);
   assign term  = $signed(mul_rsp.result[NUM_W-1:0]);
   assign dnum  = $signed(mul_rsp.result[D_W-1:0]);
   assign k_odd = {i_ff, 1'b0} - 1'b1;

   // recurrence numerator and its magnitude for the divider
   assign num     = t1_ff - term;
   assign num_mag = num[NUM_W-1] ? STEP_W'(-num) : num[STEP_W-1:0];

   // quotient by i, clamped to [-1,1]
   assign step_q = div_rsp.quotient[STEP_W-1:0];
   assign p_mag  = (step_q > STEP_W'(ONE_FX)) ? P_W'(ONE_FX) : step_q[P_W-1:0];
   assign p_new  = neg_ff ? -$signed(p_mag) : $signed(p_mag);

   // derivative numerator pieces
   assign diff  = {prod[P_W-1], prod} - {pm2_ff[P_W-1], pm2_ff};
   assign d_mag = dnum[D_W-1] ? (D_W-1)'(-dnum) : dnum[D_W-2:0];

   // final quotient saturated to the output range
   assign fq     = div_rsp.quotient;
   assign fq_big = |fq[DVD_W-1:RES_W-1];
   always_comb begin
      if (neg_ff) begin
         fres = fq_big ? {1'b1, {(RES_W-1){1'b0}}} : -$signed(fq[RES_W-1:0]);
      end else begin
         fres = fq_big ? {1'b0, {(RES_W-1){1'b1}}} : $signed(fq[RES_W-1:0]);
      end
   end

   // sequencer
   always_comb begin
      state_in         = state_ff;
      func_in          = func_ff;
      x_in             = x_ff;
      n_in             = n_ff;
      i_in             = i_ff;
      pm1_in           = pm1_ff;
      pm2_in           = pm2_ff;
      t1_in            = t1_ff;
      neg_in           = neg_ff;
      den_in           = den_ff;
      mul_cmd_in       = mul_cmd_ff;
      mul_cmd_in.start = 1'b0;
      div_cmd_in       = div_cmd_ff;
      div_cmd_in.start = 1'b0;
      rsp_valid_in     = 1'b0;
      rsp_in           = rsp_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               func_in             = req_payload.func;
               x_in                = x_clamp;
               n_in                = n_req;
               i_in                = N_W'(2);
               pm2_in              = ONE_FX;
               pm1_in              = x_clamp;
               rsp_in.domain_error = 1'b0;
               if (n_req == N_W'(0)) begin
                  rsp_valid_in  = 1'b1;
                  rsp_in.result = (req_payload.func == FUNC_POLY) ? RES_W'(ONE_FX) : '0;
               end else if (n_req == N_W'(1)) begin
                  rsp_valid_in  = 1'b1;
                  rsp_in.result = (req_payload.func == FUNC_POLY)
                                  ? {{(RES_W-P_W){x_clamp[P_W-1]}}, x_clamp}
                                  : RES_W'(ONE_FX);
               end else begin
                  mul_cmd_in = mul_op(1'b1, {x_clamp[P_W-1], x_clamp}, x_clamp);
                  state_in   = (req_payload.func == FUNC_POLY) ? ST_XP : ST_DEN;
               end
            end
         end
         // 1 - x*x, zero only at x = +-1
         ST_DEN: begin
            if (mul_rsp.done) begin
               if (prod == ONE_FX) begin
                  rsp_valid_in        = 1'b1;
                  rsp_in.result       = '0;
                  rsp_in.domain_error = 1'b1;
                  state_in            = ST_IDLE;
               end else begin
                  den_in     = DVS_W'(ONE_FX - prod);
                  mul_cmd_in = mul_op(1'b1, {x_ff[P_W-1], x_ff}, pm1_ff);
                  state_in   = ST_XP;
               end
            end
         end
         // (2i-1) * x*P_{i-1}
         ST_XP: begin
            if (mul_rsp.done) begin
               mul_cmd_in = mul_op(1'b0, {prod[P_W-1], prod}, MUL_B_W'(k_odd));
               state_in   = ST_K1;
            end
         end
         // (i-1) * P_{i-2}
         ST_K1: begin
            if (mul_rsp.done) begin
               t1_in      = term;
               mul_cmd_in = mul_op(1'b0, {pm2_ff[P_W-1], pm2_ff},
                                   MUL_B_W'(i_ff - 1'b1));
               state_in   = ST_K2;
            end
         end
         // divide the numerator magnitude by i
         ST_K2: begin
            if (mul_rsp.done) begin
               neg_in              = num[NUM_W-1];
               div_cmd_in.start    = 1'b1;
               div_cmd_in.dividend = DVD_W'({num_mag, {(DVD_W-STEP_W){1'b0}}});
               div_cmd_in.divisor  = DVS_W'(i_ff);
               div_cmd_in.bits     = STEP_BITS;
               state_in            = ST_DIV;
            end
         end
         // new P_i, then the next step or the finish
         ST_DIV: begin
            if (div_rsp.done) begin
               pm2_in = pm1_ff;
               pm1_in = p_new;
               if (i_ff == n_ff) begin
                  if (func_ff == FUNC_POLY) begin
                     rsp_valid_in        = 1'b1;
                     rsp_in.result       = {{(RES_W-P_W){p_new[P_W-1]}}, p_new};
                     rsp_in.domain_error = 1'b0;
                     state_in            = ST_IDLE;
                  end else begin
                     mul_cmd_in = mul_op(1'b1, {x_ff[P_W-1], x_ff}, p_new);
                     state_in   = ST_D1;
                  end
               end else begin
                  i_in       = i_ff + 1'b1;
                  mul_cmd_in = mul_op(1'b1, {x_ff[P_W-1], x_ff}, p_new);
                  state_in   = ST_XP;
               end
            end
         end
         // n * (x*P_n - P_{n-1})
         ST_D1: begin
            if (mul_rsp.done) begin
               mul_cmd_in = mul_op(1'b0, diff, MUL_B_W'(n_ff));
               state_in   = ST_D2;
            end
         end
         // divide by 1 - x*x, the magnitude of the negative x*x - 1, so the sign flips
         ST_D2: begin
            if (mul_rsp.done) begin
               neg_in              = ~dnum[D_W-1];
               div_cmd_in.start    = 1'b1;
               div_cmd_in.dividend = DVD_W'({d_mag, {FRAC_BITS{1'b0}}});
               div_cmd_in.divisor  = den_ff;
               div_cmd_in.bits     = FULL_BITS;
               state_in            = ST_FDIV;
            end
         end
         ST_FDIV: begin
            if (div_rsp.done) begin
               rsp_valid_in        = 1'b1;
               rsp_in.result       = fres;
               rsp_in.domain_error = 1'b0;
               state_in            = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      func_ff    <= func_in;
      x_ff       <= x_in;
      n_ff       <= n_in;
      i_ff       <= i_in;
      pm1_ff     <= pm1_in;
      pm2_ff     <= pm2_in;
      t1_ff      <= t1_in;
      neg_ff     <= neg_in;
      den_ff     <= den_in;
      rsp_ff     <= rsp_in;
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         mul_cmd_ff   <= '0;
         div_cmd_ff   <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         mul_cmd_ff   <= mul_cmd_in;
         div_cmd_ff   <= div_cmd_in;
      end
   end

   lpe_mul_unit u_mul (
      .clock (clock),
      .reset (reset),
      .cmd   (mul_cmd_ff),
      .rsp   (mul_rsp)
   );

   lpe_div_unit u_div (
      .clock (clock),
      .reset (reset),
      .cmd   (div_cmd_ff),
      .rsp   (div_rsp)
   );

   assign busy        = (state_ff != ST_IDLE);
   assign rsp_strobe  = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   // a result is only ever shown with the sequencer back at idle
   a_strobe_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> !busy)
      else $error("result strobe while sequencer busy");

   // every taken item either answers at once or starts the sequencer
   a_accept_progress: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> (rsp_strobe || busy))
      else $error("taken item neither answered nor started");

   // a domain error always returns zero
   a_error_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_payload.domain_error) |-> (rsp_payload.result == '0))
      else $error("domain error with nonzero result");

   // the two shared units are never finishing in the same cycle
   a_units_exclusive: assert property (@(posedge clock) disable iff (reset)
      !(mul_rsp.done && div_rsp.done))
      else $error("multiplier and divider finished together");

endmodule
